/* sv/ptpl_pkg.sv */
// shared widths, fixed-point constants and register codes for the point-to-plane block
`timescale 1ns / 1ps
`default_nettype none

package ptpl_pkg;

  // normals are Q1.16, rotation entries Q1.18
  localparam int NRM_WIDTH      = 18;
  localparam int NRM_FRAC       = 16;
  localparam int ROT_WIDTH      = 20;
  localparam int ROT_FRAC       = 18;
  localparam int ROT_ROW_WIDTH  = 3 * ROT_WIDTH;
  localparam int CFG_DATA_WIDTH = ROT_ROW_WIDTH;
  localparam int CFG_IDX_WIDTH  = 3;

  // identity rotation rows after reset
  localparam logic [ROT_ROW_WIDTH-1:0] ROT_ROW_A_RST = ROT_ROW_WIDTH'(1) << ROT_FRAC;
  localparam logic [ROT_ROW_WIDTH-1:0] ROT_ROW_B_RST =
    ROT_ROW_WIDTH'(1) << (ROT_FRAC + ROT_WIDTH);
  localparam logic [ROT_ROW_WIDTH-1:0] ROT_ROW_C_RST =
    ROT_ROW_WIDTH'(1) << (ROT_FRAC + 2 * ROT_WIDTH);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROT_A,
    REG_ROT_B,
    REG_ROT_C,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z
  } cfg_reg_t;

endpackage

`default_nettype wire

/* sv/point_to_plane_residual_jacobian.sv */
// point-to-plane residual and 1x6 pose jacobian, five-stage streaming pipeline
//
// one correspondence per transfer on s_*: reference point, query point and
// plane normal. one result per transfer on m_*: signed residual n.(p - R q - t),
// translation jacobian -(R^T n) and rotation jacobian (R^T n) x q, with sat_flag
// in m_tuser when any field was clamped. the pose (R, t) is to be loaded through
// the cfg_* write port while no item is in flight; the block does not enforce it.
// the pipeline takes one item per cycle while m_tready keeps the output moving;
// the five product/sum stages are each one multiplier or one three-input add deep.
// reset clears every valid bit, loads the identity rotation and a zero shift.
// when m_tready is low the output register holds its result; each stage still
// advances as long as the one after it has room, so bubbles close up and
// s_tready drops only once all five stages are full. nothing is dropped or
// issued twice across a stall.
`timescale 1ns / 1ps
`default_nettype none

module point_to_plane_residual_jacobian #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // cfg write port
  input  wire logic                                   cfg_we,
  input  wire logic [ptpl_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  wire logic [ptpl_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  // input stream
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // s_tdata, low to high: ref_x, ref_y, ref_z, qry_x, qry_y, qry_z, nrm_x, nrm_y, nrm_z
  input  wire logic [((6*COORD_WIDTH+3*ptpl_pkg::NRM_WIDTH+7)/8)*8-1:0] s_tdata,
  // output stream
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // m_tdata, low to high: residual, jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz
  output logic [((4*COORD_WIDTH+3*ptpl_pkg::NRM_WIDTH+7)/8)*8-1:0] m_tdata,
  // m_tuser: sat_flag
  output logic [0:0]                                  m_tuser
);
  import ptpl_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int NW       = NRM_WIDTH;
  localparam int RW       = ROT_WIDTH;
  // R q
  localparam int PQ_W     = RW + CW;
  localparam int RQ_SUM_W = PQ_W + 2;
  localparam int RQ_W     = RQ_SUM_W - ROT_FRAC;
  // w = R^T n
  localparam int PN_W     = NW + RW;
  localparam int W_SUM_W  = PN_W + 2;
  localparam int W_W      = W_SUM_W - ROT_FRAC;
  localparam int NEGW_W   = W_W + 1;
  // d and n.d
  localparam int D_W      = CW + 5;
  localparam int ND_W     = NW + D_W;
  localparam int ND_SUM_W = ND_W + 2;
  localparam int RES_W    = ND_SUM_W - NRM_FRAC;
  // w x q
  localparam int WQ_W     = W_W + CW;
  localparam int CR_SUM_W = WQ_W + 1;
  localparam int CR_W     = CR_SUM_W - NRM_FRAC;

  localparam logic signed [RQ_SUM_W-1:0] RQ_HALF = RQ_SUM_W'(1) << (ROT_FRAC - 1);
  localparam logic signed [W_SUM_W-1:0]  W_HALF  = W_SUM_W'(1) << (ROT_FRAC - 1);
  localparam logic signed [ND_SUM_W-1:0] ND_HALF = ND_SUM_W'(1) << (NRM_FRAC - 1);
  localparam logic signed [CR_SUM_W-1:0] CR_HALF = CR_SUM_W'(1) << (NRM_FRAC - 1);

  // clamp to a coordinate field, msb of the result is the overflow mark
  function automatic logic [CW:0] clamp_coord(input logic [RES_W-1:0] x);
    logic [RES_W-CW:0] top;
    logic              ovf;
    logic [CW-1:0]     val;
    top = x[RES_W-1:CW-1];
    ovf = (|top) && !(&top);
    val = ovf ? {x[RES_W-1], {(CW-1){!x[RES_W-1]}}} : x[CW-1:0];
    return {ovf, val};
  endfunction

  function automatic logic [NW:0] clamp_nrm(input logic [NEGW_W-1:0] x);
    logic [NEGW_W-NW:0] top;
    logic               ovf;
    logic [NW-1:0]      val;
    top = x[NEGW_W-1:NW-1];
    ovf = (|top) && !(&top);
    val = ovf ? {x[NEGW_W-1], {(NW-1){!x[NEGW_W-1]}}} : x[NW-1:0];
    return {ovf, val};
  endfunction

  // pose registers
  logic [ROT_ROW_WIDTH-1:0] rot_row [3];
  logic signed [CW-1:0]     shift   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= ROT_ROW_A_RST;
      rot_row[1] <= ROT_ROW_B_RST;
      rot_row[2] <= ROT_ROW_C_RST;
      shift[0]   <= '0;
      shift[1]   <= '0;
      shift[2]   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROT_A:   rot_row[0] <= cfg_data;
        REG_ROT_B:   rot_row[1] <= cfg_data;
        REG_ROT_C:   rot_row[2] <= cfg_data;
        REG_SHIFT_X: shift[0]   <= cfg_data[CW-1:0];
        REG_SHIFT_Y: shift[1]   <= cfg_data[CW-1:0];
        REG_SHIFT_Z: shift[2]   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage moves when it is empty or its successor moves
  logic [5:1] vld;
  logic [5:1] adv;

  always_comb begin
    adv[5] = !vld[5] || m_tready;
    for (int k = 4; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_tready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= 5; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // input unpack and rotation entries
  logic signed [CW-1:0] in_p [3];
  logic signed [CW-1:0] in_q [3];
  logic signed [NW-1:0] in_n [3];
  logic signed [RW-1:0] rot  [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p[i] = s_tdata[i*CW +: CW];
      in_q[i] = s_tdata[(3+i)*CW +: CW];
      in_n[i] = s_tdata[6*CW + i*NW +: NW];
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = rot_row[i][j*RW +: RW];
      end
    end
  end

  // stage 1: products for R q and R^T n
  logic signed [PQ_W-1:0] s1_pq [3][3];
  logic signed [PN_W-1:0] s1_pn [3][3];
  logic signed [CW-1:0]   s1_p  [3];
  logic signed [CW-1:0]   s1_q  [3];
  logic signed [NW-1:0]   s1_n  [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_pq[i][j] <= PQ_W'(rot[i][j]) * PQ_W'(in_q[j]);
          s1_pn[i][j] <= PN_W'(in_n[i]) * PN_W'(rot[i][j]);
        end
        s1_p[i] <= in_p[i];
        s1_q[i] <= in_q[i];
        s1_n[i] <= in_n[i];
      end
    end
  end

  // stage 2: row sums, round half up to Q.14 and Q.16
  logic signed [RQ_SUM_W-1:0] rq_sum [3];
  logic signed [W_SUM_W-1:0]  w_sum  [3];
  logic signed [RQ_W-1:0]     s2_rq  [3];
  logic signed [W_W-1:0]      s2_w   [3];
  logic signed [CW-1:0]       s2_p   [3];
  logic signed [CW-1:0]       s2_q   [3];
  logic signed [NW-1:0]       s2_n   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rq_sum[i] = RQ_SUM_W'(s1_pq[i][0]) + RQ_SUM_W'(s1_pq[i][1])
                + RQ_SUM_W'(s1_pq[i][2]) + RQ_HALF;
      w_sum[i]  = W_SUM_W'(s1_pn[0][i]) + W_SUM_W'(s1_pn[1][i])
                + W_SUM_W'(s1_pn[2][i]) + W_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_rq[i] <= rq_sum[i][RQ_SUM_W-1:ROT_FRAC];
        s2_w[i]  <= w_sum[i][W_SUM_W-1:ROT_FRAC];
        s2_p[i]  <= s1_p[i];
        s2_q[i]  <= s1_q[i];
        s2_n[i]  <= s1_n[i];
      end
    end
  end

  // stage 3: d = p - R q - t, translation jacobian clamp
  logic [NW:0]               jt_clamp [3];
  logic signed [D_W-1:0]     s3_d     [3];
  logic signed [W_W-1:0]     s3_w     [3];
  logic signed [CW-1:0]      s3_q     [3];
  logic signed [NW-1:0]      s3_n     [3];
  logic [NW-1:0]             s3_jt    [3];
  logic                      s3_sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      jt_clamp[i] = clamp_nrm(NEGW_W'(0) - NEGW_W'(s2_w[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_d[i]  <= D_W'(s2_p[i]) - D_W'(s2_rq[i]) - D_W'(shift[i]);
        s3_w[i]  <= s2_w[i];
        s3_q[i]  <= s2_q[i];
        s3_n[i]  <= s2_n[i];
        s3_jt[i] <= jt_clamp[i][NW-1:0];
      end
      s3_sat <= jt_clamp[0][NW] | jt_clamp[1][NW] | jt_clamp[2][NW];
    end
  end

  // stage 4: products for n.d and w x q
  logic signed [ND_W-1:0] s4_nd  [3];
  logic signed [WQ_W-1:0] s4_wqa [3];
  logic signed [WQ_W-1:0] s4_wqb [3];
  logic [NW-1:0]          s4_jt  [3];
  logic                   s4_sat;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_nd[i] <= ND_W'(s3_n[i]) * ND_W'(s3_d[i]);
        s4_jt[i] <= s3_jt[i];
      end
      // component j is w[j+1] q[j+2] - w[j+2] q[j+1], indexes wrap
      s4_wqa[0] <= WQ_W'(s3_w[1]) * WQ_W'(s3_q[2]);
      s4_wqb[0] <= WQ_W'(s3_w[2]) * WQ_W'(s3_q[1]);
      s4_wqa[1] <= WQ_W'(s3_w[2]) * WQ_W'(s3_q[0]);
      s4_wqb[1] <= WQ_W'(s3_w[0]) * WQ_W'(s3_q[2]);
      s4_wqa[2] <= WQ_W'(s3_w[0]) * WQ_W'(s3_q[1]);
      s4_wqb[2] <= WQ_W'(s3_w[1]) * WQ_W'(s3_q[0]);
      s4_sat    <= s3_sat;
    end
  end

  // stage 5: sums, rounding, clamp into the output register
  logic signed [ND_SUM_W-1:0] nd_sum;
  logic signed [CR_SUM_W-1:0] cr_sum  [3];
  logic signed [CR_W-1:0]     cr_rnd  [3];
  logic [CW:0]                res_cl;
  logic [CW:0]                jr_cl   [3];
  logic [CW-1:0]              res_o;
  logic [CW-1:0]              jr_o    [3];
  logic [NW-1:0]              jt_o    [3];
  logic                       sat_o;

  always_comb begin
    nd_sum = ND_SUM_W'(s4_nd[0]) + ND_SUM_W'(s4_nd[1]) + ND_SUM_W'(s4_nd[2]) + ND_HALF;
    res_cl = clamp_coord(nd_sum[ND_SUM_W-1:NRM_FRAC]);
    for (int i = 0; i < 3; i++) begin
      cr_sum[i] = CR_SUM_W'(s4_wqa[i]) - CR_SUM_W'(s4_wqb[i]) + CR_HALF;
      cr_rnd[i] = cr_sum[i][CR_SUM_W-1:NRM_FRAC];
      jr_cl[i]  = clamp_coord(RES_W'(cr_rnd[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      res_o <= res_cl[CW-1:0];
      for (int i = 0; i < 3; i++) begin
        jr_o[i] <= jr_cl[i][CW-1:0];
        jt_o[i] <= s4_jt[i];
      end
      sat_o <= s4_sat | res_cl[CW] | jr_cl[0][CW] | jr_cl[1][CW] | jr_cl[2][CW];
    end
  end

  assign m_tvalid = vld[5];
  assign m_tuser  = sat_o;

  always_comb begin
    m_tdata = '0;
    m_tdata[CW-1:0] = res_o;
    for (int i = 0; i < 3; i++) begin
      m_tdata[CW + i*NW +: NW]          = jt_o[i];
      m_tdata[CW + 3*NW + i*CW +: CW]   = jr_o[i];
    end
  end

endmodule

`default_nettype wire

/* sv/ptpl_checker.sv */
// port-level checks for the point-to-plane block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ptpl_checker #(
  parameter int COORD_WIDTH = 24
) (
  input wire logic                                                    clk,
  input wire logic                                                    rst,
  input wire logic                                                    s_tready,
  input wire logic                                                    m_tvalid,
  input wire logic                                                    m_tready,
  input wire logic [((4*COORD_WIDTH+3*ptpl_pkg::NRM_WIDTH+7)/8)*8-1:0] m_tdata,
  input wire logic [0:0]                                              m_tuser
);
  import ptpl_pkg::*;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high right after reset");

  // an empty output register never backs up the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low with no result pending");

  // a receiver that takes every transfer never stalls the input
  a_pass_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("s_tready low while m_tready high");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind point_to_plane_residual_jacobian ptpl_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ptpl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* test/point_to_plane_residual_jacobian_tb.sv */
// self-checking testbench for the point-to-plane residual and pose jacobian stream block
`timescale 1ns / 1ps

module point_to_plane_residual_jacobian_tb;
  import ptpl_pkg::*;

  localparam int CW = 24;
  localparam int S_W = ((6 * CW + 3 * NRM_WIDTH + 7) / 8) * 8;
  localparam int M_W = ((4 * CW + 3 * NRM_WIDTH + 7) / 8) * 8;
  localparam int ONE_C = 1 << 14;          // 1.0 in Q9.14
  localparam int UNIT = 1 << NRM_FRAC;     // 1.0 in Q1.16
  localparam int ONE_R = 1 << ROT_FRAC;    // 1.0 in Q1.18
  localparam int HALF_R = ONE_R / 2;
  localparam int COS30_R = 227023;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));
  localparam int NMAX = (1 << (NRM_WIDTH - 1)) - 1;
  localparam int NMIN = -(1 << (NRM_WIDTH - 1));
  localparam int SPAN = 1 << 20;           // +-64.0 for everyday coordinates
  localparam int LONG_HOLD = 120;
  localparam int LATENCY = 5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_B = 3'd7;

  // correspondence as carried on s_tdata, first field lowest
  typedef struct packed {
    logic [S_W-6*CW-3*NRM_WIDTH-1:0] pad;
    logic signed [NRM_WIDTH-1:0] nz, ny, nx;
    logic signed [CW-1:0] qz, qy, qx;
    logic signed [CW-1:0] pz, py, px;
  } corr_t;

  // residual and jacobian as carried on m_tdata
  typedef struct packed {
    logic [M_W-4*CW-3*NRM_WIDTH-1:0] pad;
    logic signed [CW-1:0] rz, ry, rx;
    logic signed [NRM_WIDTH-1:0] tz, ty, tx;
    logic signed [CW-1:0] res;
  } fit_t;

  typedef struct packed {
    bit sat;
    fit_t fit;
  } fit_exp_t;

  class corr_scoreboard;
    logic [ROT_ROW_WIDTH-1:0] rot_row[3];
    logic signed [CW-1:0] shift[3];
    fit_exp_t fit_exp_q[$];
    int errors;
    int checked;
    int saturated;
    string field_name[8];

    function new();
      rot_row[0] = ROT_ROW_A_RST;
      rot_row[1] = ROT_ROW_B_RST;
      rot_row[2] = ROT_ROW_C_RST;
      foreach (shift[i]) shift[i] = '0;
      field_name = '{"residual", "jac_tx", "jac_ty", "jac_tz",
                     "jac_rx", "jac_ry", "jac_rz", "sat_flag"};
      errors = 0;
      checked = 0;
      saturated = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] v);
      case (idx)
        REG_ROT_A:   rot_row[0] = v;
        REG_ROT_B:   rot_row[1] = v;
        REG_ROT_C:   rot_row[2] = v;
        REG_SHIFT_X: shift[0] = v[CW-1:0];
        REG_SHIFT_Y: shift[1] = v[CW-1:0];
        REG_SHIFT_Z: shift[2] = v[CW-1:0];
        default: ;
      endcase
    endfunction

    // half up: add half an lsb, then floor
    function longint round_off(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function longint clip(longint v, int w, inout bit sat);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1'b1;
        return hi;
      end
      if (v < lo) begin
        sat = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function int pending();
      return fit_exp_q.size();
    endfunction

    function void note_correspondence(corr_t c);
      longint pt[3], qp[3], nv[3], d[3], w[3];
      longint rm[3][3];
      fit_exp_t e;
      bit sat;
      sat = 1'b0;
      e = '0;
      pt = '{longint'(c.px), longint'(c.py), longint'(c.pz)};
      qp = '{longint'(c.qx), longint'(c.qy), longint'(c.qz)};
      nv = '{longint'(c.nx), longint'(c.ny), longint'(c.nz)};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          rm[i][j] = longint'($signed(rot_row[i][j*ROT_WIDTH +: ROT_WIDTH]));
      // offset of the reference point from the transformed query point
      for (int i = 0; i < 3; i++)
        d[i] = pt[i] - round_off(rm[i][0] * qp[0] + rm[i][1] * qp[1] + rm[i][2] * qp[2],
                                 ROT_FRAC) - longint'(shift[i]);
      e.fit.res = CW'(clip(round_off(nv[0] * d[0] + nv[1] * d[1] + nv[2] * d[2], NRM_FRAC),
                           CW, sat));
      // w = R^T n, kept unclamped for the cross product
      for (int j = 0; j < 3; j++)
        w[j] = round_off(nv[0] * rm[0][j] + nv[1] * rm[1][j] + nv[2] * rm[2][j], ROT_FRAC);
      e.fit.tx = NRM_WIDTH'(clip(-w[0], NRM_WIDTH, sat));
      e.fit.ty = NRM_WIDTH'(clip(-w[1], NRM_WIDTH, sat));
      e.fit.tz = NRM_WIDTH'(clip(-w[2], NRM_WIDTH, sat));
      e.fit.rx = CW'(clip(round_off(w[1] * qp[2] - w[2] * qp[1], NRM_FRAC), CW, sat));
      e.fit.ry = CW'(clip(round_off(w[2] * qp[0] - w[0] * qp[2], NRM_FRAC), CW, sat));
      e.fit.rz = CW'(clip(round_off(w[0] * qp[1] - w[1] * qp[0], NRM_FRAC), CW, sat));
      e.sat = sat;
      fit_exp_q.push_back(e);
    endfunction

    function void fields_of(fit_t f, bit s, output longint v[8]);
      v = '{longint'(f.res), longint'(f.tx), longint'(f.ty), longint'(f.tz),
            longint'(f.rx), longint'(f.ry), longint'(f.rz), longint'(s)};
    endfunction

    function void check_result(logic [M_W-1:0] data, logic flag);
      fit_exp_t e;
      longint gv[8], ev[8];
      if (fit_exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing expected: data %h flag %b", data, flag);
        return;
      end
      e = fit_exp_q.pop_front();
      checked++;
      if (e.sat) saturated++;
      if ($isunknown({data, flag})) begin
        errors++;
        if (errors <= 10) $display("result %0d has unknown bits: %h %b", checked, data, flag);
        return;
      end
      fields_of(e.fit, e.sat, ev);
      fields_of(fit_t'(data), flag, gv);
      for (int i = 0; i < 8; i++)
        if (gv[i] != ev[i]) begin
          errors++;
          if (errors <= 10)
            $display("result %0d %s: expected %0d, got %0d", checked, field_name[i],
                     ev[i], gv[i]);
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  corr_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int corr_sent = 0;
  int poses_loaded = 0;

  point_to_plane_residual_jacobian #(
    .COORD_WIDTH(CW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),       // ref_x..z, qry_x..z, nrm_x..z
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),       // residual, jac_tx..tz, jac_rx..rz
    .m_tuser(m_tuser)        // sat_flag
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        gap = $urandom_range(1, 16);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("point_to_plane_residual_jacobian regression: fail");
    $finish;
  end

  function automatic corr_t mk(input int px, py, pz, qx, qy, qz, nx, ny, nz);
    corr_t c;
    c = '0;
    c.px = CW'(px);
    c.py = CW'(py);
    c.pz = CW'(pz);
    c.qx = CW'(qx);
    c.qy = CW'(qy);
    c.qz = CW'(qz);
    c.nx = NRM_WIDTH'(nx);
    c.ny = NRM_WIDTH'(ny);
    c.nz = NRM_WIDTH'(nz);
    return c;
  endfunction

  function automatic corr_t random_corr();
    corr_t c;
    c = '0;
    if ($urandom_range(0, 3) == 0) begin
      // any bit pattern at all
      c.px = CW'($urandom);
      c.py = CW'($urandom);
      c.pz = CW'($urandom);
      c.qx = CW'($urandom);
      c.qy = CW'($urandom);
      c.qz = CW'($urandom);
      c.nx = NRM_WIDTH'($urandom);
      c.ny = NRM_WIDTH'($urandom);
      c.nz = NRM_WIDTH'($urandom);
    end else begin
      c.px = CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
      c.py = CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
      c.pz = CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
      c.qx = CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
      c.qy = CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
      c.qz = CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
      c.nx = NRM_WIDTH'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
      c.ny = NRM_WIDTH'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
      c.nz = NRM_WIDTH'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
    end
    return c;
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] rot_row_of(input int e0, e1, e2);
    return {ROT_WIDTH'(e2), ROT_WIDTH'(e1), ROT_WIDTH'(e0)};
  endfunction

  // random register word
  function automatic logic [CFG_DATA_WIDTH-1:0] rand_word();
    return CFG_DATA_WIDTH'({$urandom, $urandom});
  endfunction

  // shift value with junk above the coordinate width
  function automatic logic [CFG_DATA_WIDTH-1:0] shift_word(input int v);
    logic [CFG_DATA_WIDTH-1:0] x;
    x = rand_word();
    x[CW-1:0] = CW'(v);
    return x;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  task automatic send_corr(input corr_t c);
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_correspondence(c);
    corr_sent++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic load_pose(input logic [CFG_DATA_WIDTH-1:0] ra, rb, rc, sx, sy, sz);
    write_reg(REG_ROT_A, ra);
    write_reg(REG_ROT_B, rb);
    write_reg(REG_ROT_C, rc);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    poses_loaded++;
  endtask

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_corr(random_corr());
    drain();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, under the reset pose (identity, no shift)
    tx_idle_pct = 30;
    rx_idle_pct = 10;
    send_corr(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_corr(mk(ONE_C, 2 * ONE_C, 3 * ONE_C, 0, 0, 0, UNIT, 0, 0));
    send_corr(mk(ONE_C, 2 * ONE_C, 3 * ONE_C, 0, 0, 0, 0, UNIT, 0));
    send_corr(mk(ONE_C, 0, 0, ONE_C, -ONE_C, 5 * ONE_C, 0, 0, UNIT));
    // residual clamps high, then low
    send_corr(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, NMAX, NMAX, NMAX));
    send_corr(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, NMAX, NMAX, NMAX));
    // -n overflows the translation part; cross product clamps too
    send_corr(mk(0, 0, 0, CMAX, CMIN, 0, NMIN, NMIN, NMIN));
    send_corr(mk(0, 0, 0, CMAX, 0, 0, 0, NMAX, 0));
    // round half up on the residual, positive and negative ties
    send_corr(mk(32768, 0, 0, 0, 0, 0, 1, 0, 0));
    send_corr(mk(-32768, 0, 0, 0, 0, 0, 1, 0, 0));
    // ties in the rotation part
    send_corr(mk(0, 0, 0, 0, 32768, 32768, 1, 0, 0));
    send_corr(mk(CMAX, CMIN, 0, CMIN, CMAX, 1, NMIN, NMAX, 1));
    send_corr(mk('h555555, 'h555555, 'h555555, 'haaaaaa, 'haaaaaa, 'haaaaaa,
                 'h15555, 'h2aaaa, 'h15555));
    send_corr(mk('haaaaaa, 'haaaaaa, 'haaaaaa, 'h555555, 'h555555, 'h555555,
                 'h2aaaa, 'h15555, 'h2aaaa));
    send_corr(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    drain();

    // quarter turn about z with a shift; receiver holds off while input keeps coming
    load_pose(rot_row_of(0, -ONE_R, 0), rot_row_of(ONE_R, 0, 0), rot_row_of(0, 0, ONE_R),
              shift_word(24576), shift_word(-36864), shift_word(100 * ONE_C));
    rx_hold_req = 1'b1;
    run_random(40, 0, 0);
    run_random(60, pick_pct(), pick_pct());

    // half-scale row and 30 degrees about x: rounding ties on R q and on R^T n
    load_pose(rot_row_of(HALF_R, 0, 0), rot_row_of(0, COS30_R, -HALF_R),
              rot_row_of(0, HALF_R, COS30_R), shift_word(-ONE_C), shift_word(7),
              shift_word(-7));
    tx_idle_pct = 20;
    rx_idle_pct = 10;
    send_corr(mk(0, 0, 0, 1, 1, 0, UNIT, UNIT, UNIT));
    send_corr(mk(0, 0, 0, -1, -1, 0, UNIT, UNIT, UNIT));
    send_corr(mk(0, 0, 0, ONE_C, 0, 0, 1, 0, 0));
    send_corr(mk(0, 0, 0, ONE_C, 0, 0, -1, 0, 0));
    run_random(80, pick_pct(), pick_pct());

    // writes past the last register must change nothing
    write_reg(REG_SPARE_A, rand_word());
    write_reg(REG_SPARE_B, rand_word());
    // largest entries and shifts
    load_pose(rot_row_of('h7ffff, 'h7ffff, 'h7ffff), rot_row_of('h7ffff, 'h7ffff, 'h7ffff),
              rot_row_of('h7ffff, 'h7ffff, 'h7ffff), shift_word(CMAX), shift_word(CMAX),
              shift_word(CMAX));
    run_random(60, pick_pct(), pick_pct());

    // most negative entries and shifts
    load_pose(rot_row_of('h80000, 'h80000, 'h80000), rot_row_of('h80000, 'h80000, 'h80000),
              rot_row_of('h80000, 'h80000, 'h80000), shift_word(CMIN), shift_word(CMIN),
              shift_word(CMIN));
    run_random(60, pick_pct(), pick_pct());

    // arbitrary register contents
    repeat (2) begin
      load_pose(rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word());
      run_random(70, pick_pct(), pick_pct());
    end

    // back to identity, full rate on both sides
    load_pose(ROT_ROW_A_RST, ROT_ROW_B_RST, ROT_ROW_C_RST, shift_word(0), shift_word(0),
              shift_word(0));
    run_random(60, 0, 0);

    repeat (LATENCY * 4) @(posedge clk);
    $display("covered %0d correspondences over %0d loaded poses plus the reset pose",
             corr_sent, poses_loaded);
    $display("%0d results checked, %0d with a clamp, %0d mismatches",
             sb.checked, sb.saturated, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("point_to_plane_residual_jacobian regression: pass");
    end else begin
      $display("point_to_plane_residual_jacobian regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ptpl_pkg.sv
sv/point_to_plane_residual_jacobian.sv
sv/ptpl_checker.sv
test/point_to_plane_residual_jacobian_tb.sv
